// ===== rtl/wsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the wildcard star pattern matcher.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int MAX_TOKENS = 16;
    localparam int NPOS       = MAX_TOKENS + 1;
    localparam int POS_W      = $clog2(NPOS);
    localparam int LEVELS     = $clog2(NPOS);

    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 4;
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 5;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TEXT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END   = 2'd2;

    // Only position zero live: the state after reset and after an end item.
    localparam logic [NPOS-1:0] LIVE_REARM = NPOS'(1);

    typedef struct packed {
        logic [CHAR_W-1:0] lit;
        logic              any;
        logic              star;
    } t_token;

    typedef t_token [MAX_TOKENS-1:0] t_token_vec;

    typedef struct packed {
        logic [NPOS-1:0] live_next;
        logic            matched;
    } t_step_res;

endpackage

// ===== rtl/wsp_token_table.sv =====
// ----------------------------------------------------------------------------
// wsp_token_table
// Pattern token storage: one entry per token, written by load items.
// ----------------------------------------------------------------------------
module wsp_token_table (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [wsp_pkg::INDEX_W-1:0]     i_wr_index,
    input  wsp_pkg::t_token                 i_wr_token,
    output wsp_pkg::t_token_vec             o_tokens
);

    wsp_pkg::t_token_vec r_tokens;

    // Drop writes that land beyond the table.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (int'(i_wr_index) < wsp_pkg::MAX_TOKENS)) begin
            r_tokens[i_wr_index] <= i_wr_token;
        end
    end

    assign o_tokens = r_tokens;

endmodule

// ===== rtl/wsp_live_step.sv =====
// ----------------------------------------------------------------------------
// wsp_live_step
// One step of the live position set: star closure, then advance on a byte.
// ----------------------------------------------------------------------------
module wsp_live_step (
    input  logic [wsp_pkg::NPOS-1:0]    i_live,
    input  wsp_pkg::t_token_vec         i_tokens,
    input  logic [wsp_pkg::POS_W-1:0]   i_len,
    input  logic [wsp_pkg::CHAR_W-1:0]  i_char,
    output wsp_pkg::t_step_res          o_res
);

    logic [wsp_pkg::NPOS-1:0]       w_prop;
    logic [wsp_pkg::NPOS-1:0]       w_gen;
    logic [wsp_pkg::NPOS-1:0]       w_pass;
    logic [wsp_pkg::MAX_TOKENS-1:0] w_stay;
    logic [wsp_pkg::MAX_TOKENS-1:0] w_adv;

    // Closure is a prefix chain: live[k] |= live[k-1] & star[k-1] & (k-1 < len).
    // Resolve it with a log-depth parallel prefix.
    always_comb begin
        w_prop = '0;
        for (int k = 1; k < wsp_pkg::NPOS; k++) begin
            w_prop[k] = i_tokens[k-1].star && ((k - 1) < int'(i_len));
        end
        w_gen  = i_live;
        w_pass = w_prop;
        for (int lvl = 0; lvl < wsp_pkg::LEVELS; lvl++) begin
            w_gen  = w_gen | (w_pass & (w_gen << (1 << lvl)));
            w_pass = w_pass & (w_pass << (1 << lvl));
        end
    end

    // Advance every live position whose token takes this byte.
    always_comb begin
        for (int j = 0; j < wsp_pkg::MAX_TOKENS; j++) begin
            logic hit;
            hit = w_gen[j] && (j < int'(i_len))
                  && (i_tokens[j].any || (i_tokens[j].lit == i_char));
            w_stay[j] = hit && i_tokens[j].star;
            w_adv[j]  = hit && !i_tokens[j].star;
        end
        o_res.live_next = {1'b0, w_stay} | {w_adv, 1'b0};
        o_res.matched   = w_gen[i_len];
    end

endmodule

// ===== rtl/wildcard_star_pattern_match.sv =====
// ----------------------------------------------------------------------------
// wildcard_star_pattern_match
// Whole-string matcher for patterns of literal/dot tokens with optional star.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one item per transfer:
// load a pattern token, stream one text byte, or end the text. The end item
// yields one result on the output channel (o_out_valid / i_out_stall) with
// o_matched set when the whole text since the previous end matched the first
// pattern_length tokens; the matcher then re-arms for the next text.
// Pattern length is written on the config channel (i_cfg_valid / o_cfg_ready,
// always ready) while no items are in flight.
// An item is registered on transfer and processed as it leaves the input
// register: the live position set, the token table and, for an end item, the
// output register all load then, so a result is held in the output register.
// One item per cycle is sustained while no end item waits; the live-set step
// is a single level of registers around the closure prefix and byte compare.
// When the receiver stalls, the result holds; load and byte items keep
// flowing, and an end item waits in the input register until the output frees.
// Reset clears the pattern length, leaves only position zero live and empties
// both registers; the token table holds no defined value until written.
// ----------------------------------------------------------------------------
module wildcard_star_pattern_match (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [wsp_pkg::FUNC_W-1:0]     i_func,
    input  logic [wsp_pkg::INDEX_W-1:0]    i_token_index,
    input  logic [wsp_pkg::CHAR_W-1:0]     i_char_value,
    input  logic                           i_token_any,
    input  logic                           i_token_star,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_matched,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wsp_pkg::CFG_W-1:0]      i_cfg_pattern_length
);

    logic                           r_in_valid;
    logic [wsp_pkg::FUNC_W-1:0]     r_in_func;
    logic [wsp_pkg::INDEX_W-1:0]    r_in_index;
    logic [wsp_pkg::CHAR_W-1:0]     r_in_char;
    logic                           r_in_any;
    logic                           r_in_star;

    logic [wsp_pkg::CFG_W-1:0]      r_pattern_length;
    logic [wsp_pkg::NPOS-1:0]       r_live;
    logic [wsp_pkg::NPOS-1:0]       n_live;
    logic                           r_out_valid;
    logic                           r_matched;

    logic                           w_in_xfer;
    logic                           w_out_free;
    logic                           w_is_end;
    logic                           w_advance;
    logic [wsp_pkg::POS_W-1:0]      w_len;
    wsp_pkg::t_token                w_wr_token;
    wsp_pkg::t_token_vec            w_tokens;
    wsp_pkg::t_step_res             w_step;

    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_is_end    = (r_in_func == wsp_pkg::FUNC_END);
    // Only an end item needs the output slot.
    assign w_advance   = r_in_valid && (!w_is_end || w_out_free);
    assign o_in_stall  = r_in_valid && !w_advance;

    assign w_len = (int'(r_pattern_length) > wsp_pkg::MAX_TOKENS)
                   ? wsp_pkg::POS_W'(wsp_pkg::MAX_TOKENS)
                   : wsp_pkg::POS_W'(r_pattern_length);

    assign w_wr_token.lit  = r_in_char;
    assign w_wr_token.any  = r_in_any;
    assign w_wr_token.star = r_in_star;

    wsp_token_table u_table (
        .i_clk      (i_clk),
        .i_wr_en    (w_advance && (r_in_func == wsp_pkg::FUNC_WRITE)),
        .i_wr_index (r_in_index),
        .i_wr_token (w_wr_token),
        .o_tokens   (w_tokens)
    );

    wsp_live_step u_step (
        .i_live   (r_live),
        .i_tokens (w_tokens),
        .i_len    (w_len),
        .i_char   (r_in_char),
        .o_res    (w_step)
    );

    always_comb begin
        n_live = r_live;
        if (w_advance) begin
            case (r_in_func)
                wsp_pkg::FUNC_TEXT: n_live = w_step.live_next;
                wsp_pkg::FUNC_END:  n_live = wsp_pkg::LIVE_REARM;
                default:            n_live = r_live;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_pattern_length <= '0;
            r_live           <= wsp_pkg::LIVE_REARM;
        end else begin
            r_live <= n_live;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pattern_length <= i_cfg_pattern_length;
            end
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance && w_is_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise; the result bit loads when an end item advances.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_func  <= i_func;
            r_in_index <= i_token_index;
            r_in_char  <= i_char_value;
            r_in_any   <= i_token_any;
            r_in_star  <= i_token_star;
        end
        if (w_advance && w_is_end) begin
            r_matched <= w_step.matched;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;

    a_end_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_is_end) |=> (r_live == wsp_pkg::LIVE_REARM))
        else $error("live set not re-armed after end item");

    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_advance && w_is_end))
        else $error("result raised without an end item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_matched)))
        else $error("stalled result lost or overwritten");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && w_is_end && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked end item");

endmodule
